### rtl/spc_pkg.sv
// shared types and constants for the scroll position controller
package spc_pkg;

  // viewport size in pixels
  localparam int VIEW_WIDTH  = 640;
  localparam int VIEW_HEIGHT = 480;

  // one pixel in remainder units: 2^15 * 125
  localparam int FRAC_SHIFT = 15;
  localparam int FRAC_ODD   = 125;
  localparam int FRAC_ONE   = FRAC_ODD * (2 ** FRAC_SHIFT);

  // reciprocal of the odd factor, floor(2^31 / 125), estimate is exact or one low
  localparam int RECIP_SHIFT = 31;
  localparam int RECIP_W     = 25;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / FRAC_ODD);

  // arithmetic widths of the tick path
  localparam int PROD_W  = 40;  // frame_time * speed, magnitude below 2^39
  localparam int DIVN_W  = 24;  // product magnitude without the low 15 bits
  localparam int QMAG_W  = 18;  // whole pixels of one product
  localparam int QUOT_W  = 19;  // signed whole pixels
  localparam int REM_W   = 23;  // signed remainder, magnitude below FRAC_ONE
  localparam int WHOLE_W = 20;  // whole pixels after adding the carried remainder

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register port
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_SET,
    KIND_MOVE,
    KIND_RESET,
    KIND_PAUSE,
    KIND_RESUME,
    KIND_PLACE
  } kind_e;

  typedef enum logic [2:0] {
    REG_MIN_X,
    REG_MAX_X,
    REG_MIN_Y,
    REG_MAX_Y,
    REG_AXIS_MODES,
    REG_SPEED_X,
    REG_SPEED_Y,
    REG_START_POS
  } reg_e;

  // axis_modes bits
  localparam int MODE_WRAP_X = 0;
  localparam int MODE_WRAP_Y = 1;
  localparam int MODE_AUTO_X = 2;
  localparam int MODE_AUTO_Y = 3;

  typedef struct packed {
    logic signed [15:0] min_x;
    logic signed [15:0] max_x;
    logic signed [15:0] min_y;
    logic signed [15:0] max_y;
    logic [3:0]         modes;
    logic signed [23:0] speed_x;
    logic signed [23:0] speed_y;
    logic [31:0]        start_pos;
  } cfg_t;

  // one classified request as it waits in the queue
  typedef struct packed {
    logic [2:0]                kind;
    logic signed [15:0]        pos_x;
    logic signed [15:0]        pos_y;
    logic [15:0]               elem_width;
    logic [15:0]               elem_height;
    logic signed [QUOT_W-1:0]  quot_x;
    logic signed [REM_W-1:0]   rem_x;
    logic signed [QUOT_W-1:0]  quot_y;
    logic signed [REM_W-1:0]   rem_y;
  } cmd_t;

endpackage

### rtl/spc_regs.sv
// configuration registers behind the apb-style port
module spc_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output spc_pkg::cfg_t              cfg_o,
  output logic                       frac_clear_o
);

  spc_pkg::cfg_t cfg_q;
  spc_pkg::reg_e index;
  logic          wr_en;

  assign pready = 1'b1;
  assign index  = spc_pkg::reg_e'(paddr[spc_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  // a speed write drops both carried remainders
  assign frac_clear_o = wr_en && ((index == spc_pkg::REG_SPEED_X) ||
                                  (index == spc_pkg::REG_SPEED_Y));

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (index)
        spc_pkg::REG_MIN_X:      cfg_q.min_x     <= pwdata[15:0];
        spc_pkg::REG_MAX_X:      cfg_q.max_x     <= pwdata[15:0];
        spc_pkg::REG_MIN_Y:      cfg_q.min_y     <= pwdata[15:0];
        spc_pkg::REG_MAX_Y:      cfg_q.max_y     <= pwdata[15:0];
        spc_pkg::REG_AXIS_MODES: cfg_q.modes     <= pwdata[3:0];
        spc_pkg::REG_SPEED_X:    cfg_q.speed_x   <= pwdata[23:0];
        spc_pkg::REG_SPEED_Y:    cfg_q.speed_y   <= pwdata[23:0];
        spc_pkg::REG_START_POS:  cfg_q.start_pos <= pwdata;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (index)
      spc_pkg::REG_MIN_X:      prdata = {16'b0, cfg_q.min_x};
      spc_pkg::REG_MAX_X:      prdata = {16'b0, cfg_q.max_x};
      spc_pkg::REG_MIN_Y:      prdata = {16'b0, cfg_q.min_y};
      spc_pkg::REG_MAX_Y:      prdata = {16'b0, cfg_q.max_y};
      spc_pkg::REG_AXIS_MODES: prdata = {28'b0, cfg_q.modes};
      spc_pkg::REG_SPEED_X:    prdata = {8'b0, cfg_q.speed_x};
      spc_pkg::REG_SPEED_Y:    prdata = {8'b0, cfg_q.speed_y};
      spc_pkg::REG_START_POS:  prdata = cfg_q.start_pos;
    endcase
  end

endmodule

### rtl/spc_front.sv
// front end: request intake, speed products and split into whole pixels and remainder
module spc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 kind_i,
  input  logic signed [15:0]         pos_x_i,
  input  logic signed [15:0]         pos_y_i,
  input  logic [15:0]                elem_width_i,
  input  logic [15:0]                elem_height_i,
  input  logic [15:0]                frame_time_i,
  input  spc_pkg::cfg_t              cfg_i,
  input  logic [spc_pkg::QCNT_W-1:0] count_i,
  output logic                       push_o,
  output spc_pkg::cmd_t              cmd_o
);

  typedef struct packed {
    logic                        neg;
    logic [spc_pkg::DIVN_W-1:0]  n;
    logic [spc_pkg::QMAG_W-1:0]  q0;
    logic [spc_pkg::FRAC_SHIFT-1:0] low;
  } div_t;

  typedef struct packed {
    logic signed [spc_pkg::QUOT_W-1:0] quot;
    logic signed [spc_pkg::REM_W-1:0]  rem;
  } split_t;

  localparam int RPROD_W = spc_pkg::DIVN_W + spc_pkg::RECIP_W;

  // magnitude, drop the power-of-two factor, reciprocal estimate
  function automatic div_t estimate(logic signed [spc_pkg::PROD_W-1:0] p);
    logic [spc_pkg::PROD_W-1:0] mag;
    logic [RPROD_W-1:0]         rprod;
    div_t                       res;
    mag       = p[spc_pkg::PROD_W-1] ? (~p + 1'b1) : p;
    res.neg   = p[spc_pkg::PROD_W-1];
    res.n     = mag[spc_pkg::FRAC_SHIFT +: spc_pkg::DIVN_W];
    res.low   = mag[spc_pkg::FRAC_SHIFT-1:0];
    rprod     = RPROD_W'(res.n) * RPROD_W'(spc_pkg::RECIP);
    res.q0    = rprod[spc_pkg::RECIP_SHIFT +: spc_pkg::QMAG_W];
    return res;
  endfunction

  // correct the estimate by one and put the sign back
  function automatic split_t finish(div_t d);
    logic [spc_pkg::DIVN_W:0]       back;
    logic [spc_pkg::DIVN_W:0]       r_full;
    logic [7:0]                     r;
    logic [spc_pkg::QMAG_W-1:0]     q;
    logic [spc_pkg::REM_W-1:0]      rmag;
    logic [spc_pkg::QUOT_W-1:0]     qmag;
    split_t                         res;
    back   = (spc_pkg::DIVN_W+1)'(d.q0) * (spc_pkg::DIVN_W+1)'(spc_pkg::FRAC_ODD);
    r_full = (spc_pkg::DIVN_W+1)'(d.n) - back;
    r      = r_full[7:0];
    q      = d.q0;
    if (r >= 8'(spc_pkg::FRAC_ODD)) begin
      q = q + 1'b1;
      r = r - 8'(spc_pkg::FRAC_ODD);
    end
    rmag     = {1'b0, r[6:0], d.low};
    qmag     = {1'b0, q};
    res.quot = d.neg ? -$signed(qmag) : $signed(qmag);
    res.rem  = d.neg ? -$signed(rmag) : $signed(rmag);
    return res;
  endfunction

  logic                               accept;
  logic [spc_pkg::QCNT_W:0]           busy;
  logic signed [spc_pkg::PROD_W:0]    prod_x_full;
  logic signed [spc_pkg::PROD_W:0]    prod_y_full;

  logic                               v1_q;
  logic [2:0]                         kind1_q;
  logic signed [15:0]                 px1_q;
  logic signed [15:0]                 py1_q;
  logic [15:0]                        ew1_q;
  logic [15:0]                        eh1_q;
  logic signed [spc_pkg::PROD_W-1:0]  prod_x_q;
  logic signed [spc_pkg::PROD_W-1:0]  prod_y_q;

  logic                               v2_q;
  logic [2:0]                         kind2_q;
  logic signed [15:0]                 px2_q;
  logic signed [15:0]                 py2_q;
  logic [15:0]                        ew2_q;
  logic [15:0]                        eh2_q;
  div_t                               div_x_q;
  div_t                               div_y_q;

  split_t                             split_x;
  split_t                             split_y;

  // hold off while queue plus requests in flight would overfill the queue
  assign busy = (spc_pkg::QCNT_W+1)'(count_i) + (spc_pkg::QCNT_W+1)'(v1_q)
              + (spc_pkg::QCNT_W+1)'(v2_q);
  assign in_stall_o = busy >= (spc_pkg::QCNT_W+1)'(spc_pkg::QUEUE_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  // frame time times speed
  assign prod_x_full = $signed({1'b0, frame_time_i}) * cfg_i.speed_x;
  assign prod_y_full = $signed({1'b0, frame_time_i}) * cfg_i.speed_y;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  // stage one: request fields and products
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind1_q  <= kind_i;
      px1_q    <= pos_x_i;
      py1_q    <= pos_y_i;
      ew1_q    <= elem_width_i;
      eh1_q    <= elem_height_i;
      prod_x_q <= prod_x_full[spc_pkg::PROD_W-1:0];
      prod_y_q <= prod_y_full[spc_pkg::PROD_W-1:0];
    end
  end

  // stage two: reciprocal estimates
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      kind2_q <= kind1_q;
      px2_q   <= px1_q;
      py2_q   <= py1_q;
      ew2_q   <= ew1_q;
      eh2_q   <= eh1_q;
      div_x_q <= estimate(prod_x_q);
      div_y_q <= estimate(prod_y_q);
    end
  end

  // final correction feeds the queue
  assign split_x = finish(div_x_q);
  assign split_y = finish(div_y_q);

  assign push_o = v2_q;
  always_comb begin
    cmd_o.kind        = kind2_q;
    cmd_o.pos_x       = px2_q;
    cmd_o.pos_y       = py2_q;
    cmd_o.elem_width  = ew2_q;
    cmd_o.elem_height = eh2_q;
    cmd_o.quot_x      = split_x.quot;
    cmd_o.rem_x       = split_x.rem;
    cmd_o.quot_y      = split_y.quot;
    cmd_o.rem_y       = split_y.rem;
  end

endmodule

### rtl/spc_queue.sv
// short request queue between front and back
module spc_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  spc_pkg::cmd_t              cmd_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output spc_pkg::cmd_t              head_o,
  output logic [spc_pkg::QCNT_W-1:0] count_o
);

  spc_pkg::cmd_t               entry_q [spc_pkg::QUEUE_DEPTH];
  logic [spc_pkg::QPTR_W-1:0]  wr_ptr_q;
  logic [spc_pkg::QPTR_W-1:0]  rd_ptr_q;
  logic [spc_pkg::QCNT_W-1:0]  count_q;

  assign valid_o = count_q != '0;
  assign head_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### rtl/spc_back.sv
// back end: scroll state, command execution and result register
module spc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spc_pkg::cfg_t      cfg_i,
  input  logic               frac_clear_i,
  input  logic               head_valid_i,
  input  spc_pkg::cmd_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] scroll_x_o,
  output logic signed [15:0] scroll_y_o,
  output logic signed [17:0] draw_x_o,
  output logic signed [17:0] draw_y_o,
  output logic               on_screen_o,
  output logic               wrap_right_o,
  output logic               wrap_bottom_o
);

  typedef struct packed {
    logic signed [spc_pkg::WHOLE_W-1:0] whole;
    logic signed [spc_pkg::REM_W-1:0]   frac;
  } acc_t;

  // add the precomputed split to the carried remainder, keep truncation toward zero
  function automatic acc_t accum(logic signed [spc_pkg::REM_W-1:0]  frac,
                                 logic signed [spc_pkg::QUOT_W-1:0] quot,
                                 logic signed [spc_pkg::REM_W-1:0]  rem);
    logic signed [spc_pkg::REM_W:0]     t;
    logic signed [spc_pkg::REM_W:0]     one;
    logic signed [spc_pkg::WHOLE_W-1:0] w;
    acc_t                               res;
    one = (spc_pkg::REM_W+1)'(spc_pkg::FRAC_ONE);
    t   = (spc_pkg::REM_W+1)'(frac) + (spc_pkg::REM_W+1)'(rem);
    w   = spc_pkg::WHOLE_W'(quot);
    if (t >= one) begin
      t = t - one;
      w = w + spc_pkg::WHOLE_W'(1);
    end else if (t <= -one) begin
      t = t + one;
      w = w - spc_pkg::WHOLE_W'(1);
    end
    if (w > 0 && t < 0) begin
      w = w - spc_pkg::WHOLE_W'(1);
      t = t + one;
    end else if (w < 0 && t > 0) begin
      w = w + spc_pkg::WHOLE_W'(1);
      t = t - one;
    end
    res.whole = w;
    res.frac  = t[spc_pkg::REM_W-1:0];
    return res;
  endfunction

  // one axis step: zero delta leaves it alone, else clamp or fold once
  function automatic logic signed [15:0] axis_move(logic signed [15:0] p,
                                                   logic signed [spc_pkg::WHOLE_W-1:0] d,
                                                   logic signed [15:0] lo,
                                                   logic signed [15:0] hi,
                                                   logic tor);
    logic signed [21:0] v;
    logic signed [21:0] span;
    logic signed [15:0] res;
    span = 22'(hi) - 22'(lo);
    v    = 22'(p) + 22'(d);
    if (tor) begin
      if (v < 22'(lo)) begin
        v = v + span;
      end else if (v > 22'(hi)) begin
        v = v - span;
      end
    end else begin
      if (v < 22'(lo)) begin
        v = 22'(lo);
      end else if (v > 22'(hi)) begin
        v = 22'(hi);
      end
    end
    res = (d == '0) ? p : v[15:0];
    return res;
  endfunction

  // wrap region in view when the upper bound is less than a view away
  function automatic logic near_edge(logic signed [15:0] hi, logic signed [15:0] p,
                                     logic signed [17:0] view);
    logic signed [17:0] gap;
    gap = 18'(hi) - 18'(p);
    return gap < view;
  endfunction

  logic signed [15:0]              pos_x_q, pos_x_d;
  logic signed [15:0]              pos_y_q, pos_y_d;
  logic signed [spc_pkg::REM_W-1:0] frac_x_q, frac_x_d;
  logic signed [spc_pkg::REM_W-1:0] frac_y_q, frac_y_d;
  logic signed [16:0]              span_x_q, span_x_d;
  logic signed [16:0]              span_y_q, span_y_d;
  logic [1:0]                      wrap_q, wrap_d;
  logic                            running_q, running_d;

  logic                            out_valid_q;
  logic signed [15:0]              scroll_x_q, scroll_y_q;
  logic signed [17:0]              draw_x_q, draw_y_q, draw_x_d, draw_y_d;
  logic                            on_screen_q, on_screen_d;

  logic                            fire;
  logic                            flags_upd;
  logic                            auto_x, auto_y;
  acc_t                            acc_x, acc_y;
  logic signed [spc_pkg::WHOLE_W-1:0] dx, dy;
  logic signed [19:0]              ex, ey, exw, eyh;
  logic signed [16:0]              sx_full, sy_full;

  // a command runs when one waits and the result register frees up
  assign fire  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = fire;

  assign auto_x = cfg_i.modes[spc_pkg::MODE_AUTO_X] && (cfg_i.speed_x != '0);
  assign auto_y = cfg_i.modes[spc_pkg::MODE_AUTO_Y] && (cfg_i.speed_y != '0);
  assign acc_x  = accum(frac_x_q, head_i.quot_x, head_i.rem_x);
  assign acc_y  = accum(frac_y_q, head_i.quot_y, head_i.rem_y);

  assign sx_full = 17'(cfg_i.max_x) - 17'(cfg_i.min_x);
  assign sy_full = 17'(cfg_i.max_y) - 17'(cfg_i.min_y);

  // command execution
  always_comb begin
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    frac_x_d    = frac_x_q;
    frac_y_d    = frac_y_q;
    span_x_d    = span_x_q;
    span_y_d    = span_y_q;
    running_d   = running_q;
    flags_upd   = 1'b0;
    draw_x_d    = '0;
    draw_y_d    = '0;
    on_screen_d = 1'b0;
    dx          = '0;
    dy          = '0;
    ex          = '0;
    ey          = '0;
    exw         = '0;
    eyh         = '0;
    unique case (spc_pkg::kind_e'(head_i.kind))
      spc_pkg::KIND_TICK: begin
        if (running_q) begin
          if (auto_x) begin
            dx       = acc_x.whole;
            frac_x_d = acc_x.frac;
          end
          if (auto_y) begin
            dy       = acc_y.whole;
            frac_y_d = acc_y.frac;
          end
          pos_x_d   = axis_move(pos_x_q, dx, cfg_i.min_x, cfg_i.max_x,
                                cfg_i.modes[spc_pkg::MODE_WRAP_X]);
          pos_y_d   = axis_move(pos_y_q, dy, cfg_i.min_y, cfg_i.max_y,
                                cfg_i.modes[spc_pkg::MODE_WRAP_Y]);
          flags_upd = 1'b1;
        end
      end
      spc_pkg::KIND_SET: begin
        pos_x_d   = head_i.pos_x;
        pos_y_d   = head_i.pos_y;
        frac_x_d  = '0;
        frac_y_d  = '0;
        flags_upd = 1'b1;
      end
      spc_pkg::KIND_MOVE: begin
        pos_x_d   = axis_move(pos_x_q, spc_pkg::WHOLE_W'(head_i.pos_x), cfg_i.min_x,
                              cfg_i.max_x, cfg_i.modes[spc_pkg::MODE_WRAP_X]);
        pos_y_d   = axis_move(pos_y_q, spc_pkg::WHOLE_W'(head_i.pos_y), cfg_i.min_y,
                              cfg_i.max_y, cfg_i.modes[spc_pkg::MODE_WRAP_Y]);
        flags_upd = 1'b1;
      end
      spc_pkg::KIND_RESET: begin
        pos_x_d   = cfg_i.start_pos[15:0];
        pos_y_d   = cfg_i.start_pos[31:16];
        frac_x_d  = '0;
        frac_y_d  = '0;
        span_x_d  = cfg_i.modes[spc_pkg::MODE_WRAP_X] ? sx_full : '0;
        span_y_d  = cfg_i.modes[spc_pkg::MODE_WRAP_Y] ? sy_full : '0;
        flags_upd = 1'b1;
      end
      spc_pkg::KIND_PAUSE: begin
        running_d = 1'b0;
      end
      spc_pkg::KIND_RESUME: begin
        running_d = 1'b1;
      end
      spc_pkg::KIND_PLACE: begin
        ex  = 20'(head_i.pos_x) - 20'(pos_x_q);
        ey  = 20'(head_i.pos_y) - 20'(pos_y_q);
        exw = ex + $signed({4'b0, head_i.elem_width});
        eyh = ey + $signed({4'b0, head_i.elem_height});
        // left of the view with the right wrap visible: draw one span further
        if (wrap_q[0] && exw < 0) begin
          ex  = ex + 20'(span_x_q);
          exw = exw + 20'(span_x_q);
        end
        if (wrap_q[1] && eyh < 0) begin
          ey  = ey + 20'(span_y_q);
          eyh = eyh + 20'(span_y_q);
        end
        on_screen_d = (exw > 0) && (eyh > 0) && (ex < 20'(spc_pkg::VIEW_WIDTH)) &&
                      (ey < 20'(spc_pkg::VIEW_HEIGHT));
        draw_x_d    = ex[17:0];
        draw_y_d    = ey[17:0];
      end
      default: begin
      end
    endcase
    wrap_d = wrap_q;
    if (flags_upd) begin
      wrap_d[0] = cfg_i.modes[spc_pkg::MODE_WRAP_X] &&
                  near_edge(cfg_i.max_x, pos_x_d, 18'(spc_pkg::VIEW_WIDTH));
      wrap_d[1] = cfg_i.modes[spc_pkg::MODE_WRAP_Y] &&
                  near_edge(cfg_i.max_y, pos_y_d, 18'(spc_pkg::VIEW_HEIGHT));
    end
  end

  // scroll state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      frac_x_q  <= '0;
      frac_y_q  <= '0;
      span_x_q  <= '0;
      span_y_q  <= '0;
      wrap_q    <= '0;
      running_q <= 1'b1;
    end else begin
      if (fire) begin
        pos_x_q   <= pos_x_d;
        pos_y_q   <= pos_y_d;
        span_x_q  <= span_x_d;
        span_y_q  <= span_y_d;
        wrap_q    <= wrap_d;
        running_q <= running_d;
      end
      if (frac_clear_i) begin
        frac_x_q <= '0;
        frac_y_q <= '0;
      end else if (fire) begin
        frac_x_q <= frac_x_d;
        frac_y_q <= frac_y_d;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      scroll_x_q  <= pos_x_d;
      scroll_y_q  <= pos_y_d;
      draw_x_q    <= draw_x_d;
      draw_y_q    <= draw_y_d;
      on_screen_q <= on_screen_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scroll_x_o    = scroll_x_q;
  assign scroll_y_o    = scroll_y_q;
  assign draw_x_o      = draw_x_q;
  assign draw_y_o      = draw_y_q;
  assign on_screen_o   = on_screen_q;
  assign wrap_right_o  = wrap_q[0];
  assign wrap_bottom_o = wrap_q[1];

endmodule

### rtl/scroll_position_controller.sv
// top level of the two-axis scroll position controller
//
//   channel   direction  handshake              payload
//   request   in         in_valid_i/in_stall_o  kind, pos_x/y, elem_width/height, frame_time
//   result    out        out_valid_o/out_stall_i scroll_x/y, draw_x/y, on_screen, wrap flags
//   config    in         psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// one request per cycle sustained while results are not stalled; from acceptance to result each passes
// two front stages (speed product, reciprocal estimate), the queue, and the back stage
// whose update of position and remainder sets the rate.
// reset clears position, remainders, spans and wrap flags and leaves scrolling running.
// the result register lets requests keep entering while a result is stalled; intake
// stalls once queued requests plus those in the two front stages reach four.
module scroll_position_controller (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 kind_i,
  input  logic signed [15:0]         pos_x_i,
  input  logic signed [15:0]         pos_y_i,
  input  logic [15:0]                elem_width_i,
  input  logic [15:0]                elem_height_i,
  input  logic [15:0]                frame_time_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [15:0]         scroll_x_o,
  output logic signed [15:0]         scroll_y_o,
  output logic signed [17:0]         draw_x_o,
  output logic signed [17:0]         draw_y_o,
  output logic                       on_screen_o,
  output logic                       wrap_right_o,
  output logic                       wrap_bottom_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  spc_pkg::cfg_t               cfg;
  logic                        frac_clear;
  logic                        push;
  spc_pkg::cmd_t               push_cmd;
  logic                        pop;
  logic                        head_valid;
  spc_pkg::cmd_t               head;
  logic [spc_pkg::QCNT_W-1:0]  count;

  // configuration registers
  spc_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .cfg_o        (cfg),
    .frac_clear_o (frac_clear)
  );

  // intake and tick precompute
  spc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .elem_width_i  (elem_width_i),
    .elem_height_i (elem_height_i),
    .frame_time_i  (frame_time_i),
    .cfg_i         (cfg),
    .count_i       (count),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  // queue between front and back
  spc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head),
    .count_o (count)
  );

  // execution and results
  spc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .frac_clear_i  (frac_clear),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scroll_x_o    (scroll_x_o),
    .scroll_y_o    (scroll_y_o),
    .draw_x_o      (draw_x_o),
    .draw_y_o      (draw_y_o),
    .on_screen_o   (on_screen_o),
    .wrap_right_o  (wrap_right_o),
    .wrap_bottom_o (wrap_bottom_o)
  );

endmodule

### test/tb_scroll_position_controller.sv
// testbench for the scroll position controller: self-checking against a built-in predictor
module tb_scroll_position_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import spc_pkg::*;

  // unused request kind, must leave all state alone
  localparam logic [2:0] KIND_SPARE = 3'd7;
  // one pixel in remainder units: 1000 ms * 16 per ms * 256 per pixel
  localparam longint SUBPIXELS = 64'sd4096000;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 160;

  typedef enum {
    SET_WINDOW,
    SET_FULL_FAST,
    SET_FULL_REVERSE,
    SET_INVERTED,
    SET_ZERO,
    SET_ANY
  } setting_e;

  typedef struct {
    logic [2:0]         kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        elem_width;
    logic [15:0]        elem_height;
    logic [15:0]        frame_time;
  } request_t;

  typedef struct {
    logic signed [15:0] scroll_x;
    logic signed [15:0] scroll_y;
    logic signed [17:0] draw_x;
    logic signed [17:0] draw_y;
    logic               on_screen;
    logic               wrap_right;
    logic               wrap_bottom;
  } view_t;

  // viewport tracker: predicts each result and compares what comes out
  class view_tracker;
    longint lo_x, hi_x, lo_y, hi_y;
    logic [3:0] modes;
    longint rate_x, rate_y;
    logic [31:0] home;
    longint px, py;
    longint rem_x, rem_y;
    longint span_x, span_y;
    logic [1:0] flags;
    bit running;
    view_t expected[$];
    int errors;
    int results;
    int kind_seen[8];

    function new();
      lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
      modes = '0; rate_x = 0; rate_y = 0; home = '0;
      px = 0; py = 0; rem_x = 0; rem_y = 0;
      span_x = 0; span_y = 0; flags = '0; running = 1'b1;
      errors = 0; results = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function longint sext16(logic [15:0] v);
      return longint'($signed(v));
    endfunction

    function longint sext17(logic [16:0] v);
      return longint'($signed(v));
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void write_reg(reg_e idx, logic [31:0] v);
      case (idx)
        REG_MIN_X:      lo_x = sext16(v[15:0]);
        REG_MAX_X:      hi_x = sext16(v[15:0]);
        REG_MIN_Y:      lo_y = sext16(v[15:0]);
        REG_MAX_Y:      hi_y = sext16(v[15:0]);
        REG_AXIS_MODES: modes = v[3:0];
        REG_SPEED_X: begin
          rate_x = longint'($signed(v[23:0]));
          rem_x = 0;
          rem_y = 0;
        end
        REG_SPEED_Y: begin
          rate_y = longint'($signed(v[23:0]));
          rem_x = 0;
          rem_y = 0;
        end
        REG_START_POS:  home = v;
        default: ;
      endcase
    endfunction

    // one axis step: zero delta untouched, else clamp or single fold, then 16-bit wrap
    function longint fold_axis(longint p, longint d, longint lo, longint hi, bit toroidal);
      longint v;
      v = p + d;
      if (d == 0) return p;
      if (toroidal) begin
        if (v < lo) v = v + (hi - lo);
        else if (v > hi) v = v - (hi - lo);
      end else begin
        if (v < lo) v = lo;
        else if (v > hi) v = hi;
      end
      return sext16(v[15:0]);
    endfunction

    function void refresh_flags();
      flags[0] = modes[MODE_WRAP_X] && ((hi_x - px) < VIEW_WIDTH);
      flags[1] = modes[MODE_WRAP_Y] && ((hi_y - py) < VIEW_HEIGHT);
    endfunction

    function void shift_view(longint dx, longint dy);
      px = fold_axis(px, dx, lo_x, hi_x, modes[MODE_WRAP_X]);
      py = fold_axis(py, dy, lo_y, hi_y, modes[MODE_WRAP_Y]);
      refresh_flags();
    endfunction

    function void note_request(request_t r);
      longint x, y, xw, yh, dx, dy;
      view_t v;
      v.draw_x = '0;
      v.draw_y = '0;
      v.on_screen = 1'b0;
      kind_seen[r.kind]++;
      case (r.kind)
        KIND_TICK: begin
          if (running) begin
            dx = 0;
            dy = 0;
            // whole pixels leave the remainder, truncated toward zero
            if (modes[MODE_AUTO_X] && rate_x != 0) begin
              rem_x += longint'(r.frame_time) * rate_x;
              dx = rem_x / SUBPIXELS;
              rem_x -= dx * SUBPIXELS;
            end
            if (modes[MODE_AUTO_Y] && rate_y != 0) begin
              rem_y += longint'(r.frame_time) * rate_y;
              dy = rem_y / SUBPIXELS;
              rem_y -= dy * SUBPIXELS;
            end
            shift_view(dx, dy);
          end
        end
        KIND_SET: begin
          px = longint'(r.pos_x);
          py = longint'(r.pos_y);
          rem_x = 0;
          rem_y = 0;
          refresh_flags();
        end
        KIND_MOVE: shift_view(longint'(r.pos_x), longint'(r.pos_y));
        KIND_RESET: begin
          px = sext16(home[15:0]);
          py = sext16(home[31:16]);
          rem_x = 0;
          rem_y = 0;
          span_x = modes[MODE_WRAP_X] ? sext17(17'(hi_x - lo_x)) : 0;
          span_y = modes[MODE_WRAP_Y] ? sext17(17'(hi_y - lo_y)) : 0;
          refresh_flags();
        end
        KIND_PAUSE:  running = 1'b0;
        KIND_RESUME: running = 1'b1;
        KIND_PLACE: begin
          x = longint'(r.pos_x) - px;
          y = longint'(r.pos_y) - py;
          xw = x + longint'(r.elem_width);
          yh = y + longint'(r.elem_height);
          // element fully left or above: draw it in the wrapped copy
          if (flags[0] && xw < 0) begin
            x += span_x;
            xw += span_x;
          end
          if (flags[1] && yh < 0) begin
            y += span_y;
            yh += span_y;
          end
          v.on_screen = (xw > 0) && (yh > 0) && (x < VIEW_WIDTH) && (y < VIEW_HEIGHT);
          v.draw_x = x[17:0];
          v.draw_y = y[17:0];
        end
        default: ;
      endcase
      v.scroll_x = px[15:0];
      v.scroll_y = py[15:0];
      v.wrap_right = flags[0];
      v.wrap_bottom = flags[1];
      expected.push_back(v);
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(view_t got);
      view_t want;
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: result with no request waiting, scroll %0d,%0d",
                 $time, got.scroll_x, got.scroll_y);
        return;
      end
      want = expected.pop_front();
      results++;
      check_field("scroll_x", want.scroll_x, got.scroll_x);
      check_field("scroll_y", want.scroll_y, got.scroll_y);
      check_field("draw_x", want.draw_x, got.draw_x);
      check_field("draw_y", want.draw_y, got.draw_y);
      check_field("on_screen", want.on_screen, got.on_screen);
      check_field("wrap_right", want.wrap_right, got.wrap_right);
      check_field("wrap_bottom", want.wrap_bottom, got.wrap_bottom);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         kind_i = '0;
  logic signed [15:0] pos_x_i = '0;
  logic signed [15:0] pos_y_i = '0;
  logic [15:0]        elem_width_i = '0;
  logic [15:0]        elem_height_i = '0;
  logic [15:0]        frame_time_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] scroll_x_o;
  logic signed [15:0] scroll_y_o;
  logic signed [17:0] draw_x_o;
  logic signed [17:0] draw_y_o;
  logic               on_screen_o;
  logic               wrap_right_o;
  logic               wrap_bottom_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  view_tracker sb;
  bit hold_results = 1'b0;
  int settings_count = 0;
  int idle_cycles = 0;

  scroll_position_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .elem_width_i  (elem_width_i),
    .elem_height_i (elem_height_i),
    .frame_time_i  (frame_time_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scroll_x_o    (scroll_x_o),
    .scroll_y_o    (scroll_y_o),
    .draw_x_o      (draw_x_o),
    .draw_y_o      (draw_y_o),
    .on_screen_o   (on_screen_o),
    .wrap_right_o  (wrap_right_o),
    .wrap_bottom_o (wrap_bottom_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // register write: setup then access cycle
  task automatic write_reg(input reg_e idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(int'(idx) * 4);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [31:0] lo_x, hi_x, lo_y, hi_y, m, sx, sy, home);
    write_reg(REG_MIN_X, lo_x);
    write_reg(REG_MAX_X, hi_x);
    write_reg(REG_MIN_Y, lo_y);
    write_reg(REG_MAX_Y, hi_y);
    write_reg(REG_AXIS_MODES, m);
    write_reg(REG_SPEED_X, sx);
    write_reg(REG_SPEED_Y, sy);
    write_reg(REG_START_POS, home);
    settings_count++;
  endtask

  // random value between two bounds widened by a margin, kept in 16 bits
  function automatic logic [15:0] near(longint a, longint b, int margin);
    longint lo, hi;
    lo = ((a < b) ? a : b) - margin;
    hi = ((a < b) ? b : a) + margin;
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    return 16'(lo + longint'($urandom_range(0, 32'(hi - lo))));
  endfunction

  task automatic random_settings(input setting_e s);
    int lo_x, hi_x, lo_y, hi_y;
    logic [31:0] m, sx, sy, home;
    lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
    m = '0; sx = '0; sy = '0; home = '0;
    case (s)
      SET_WINDOW, SET_INVERTED: begin
        if (s == SET_WINDOW) begin
          lo_x = -int'($urandom_range(0, 1500));
          hi_x = lo_x + int'($urandom_range(1, 3000));
          lo_y = -int'($urandom_range(0, 1500));
          hi_y = lo_y + int'($urandom_range(1, 3000));
        end else begin
          lo_x = int'($urandom_range(0, 1000));
          hi_x = lo_x - int'($urandom_range(1, 800));
          lo_y = int'($urandom_range(0, 1000));
          hi_y = lo_y - int'($urandom_range(1, 800));
        end
        m = 32'($urandom_range(0, 15));
        if ($urandom_range(0, 2) != 0) m[3:2] = 2'b11;
        sx = 32'(int'($urandom_range(0, 524288)) - 262144);
        sy = 32'(int'($urandom_range(0, 524288)) - 262144);
        home = {near(lo_y, hi_y, 200), near(lo_x, hi_x, 200)};
      end
      SET_FULL_FAST: begin
        lo_x = -32768; hi_x = 32767; lo_y = -32768; hi_y = 32767;
        m = 32'hF;
        sx = 32'(8388607);
        sy = 32'(8388607);
        home = 32'h7FFF_7FFF;
      end
      SET_FULL_REVERSE: begin
        lo_x = -32768; hi_x = 32767; lo_y = -32768; hi_y = 32767;
        m = 32'hF;
        sx = 32'(-8388608);
        sy = 32'(-8388608);
        home = 32'h8000_8000;
      end
      SET_ANY: begin
        lo_x = int'($urandom()); hi_x = int'($urandom());
        lo_y = int'($urandom()); hi_y = int'($urandom());
        m = $urandom();
        sx = $urandom();
        sy = $urandom();
        home = $urandom();
      end
      default: ;
    endcase
    apply_settings(32'(lo_x), 32'(hi_x), 32'(lo_y), 32'(hi_y), m, sx, sy, home);
  endtask

  function automatic request_t make_request(logic [2:0] k, logic [15:0] x, logic [15:0] y,
                                            logic [15:0] w, logic [15:0] h, logic [15:0] ft);
    request_t r;
    r.kind = k;
    r.pos_x = x;
    r.pos_y = y;
    r.elem_width = w;
    r.elem_height = h;
    r.frame_time = ft;
    return r;
  endfunction

  // move delta: mostly small, some zero, some anywhere
  function automatic logic [15:0] random_delta();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) return '0;
    if (pick < 17) return 16'(int'($urandom_range(0, 800)) - 400);
    return 16'($urandom());
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick;
    r = make_request('0, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                     16'($urandom()), 16'($urandom()));
    pick = $urandom_range(0, 99);
    if (pick < 34) r.kind = KIND_TICK;
    else if (pick < 54) r.kind = KIND_MOVE;
    else if (pick < 62) r.kind = KIND_SET;
    else if (pick < 67) r.kind = KIND_RESET;
    else if (pick < 71) r.kind = KIND_PAUSE;
    else if (pick < 78) r.kind = KIND_RESUME;
    else if (pick < 97) r.kind = KIND_PLACE;
    else r.kind = KIND_SPARE;
    case (r.kind)
      KIND_TICK: begin
        if ($urandom_range(0, 4) != 0) r.frame_time = 16'($urandom_range(0, 800));
      end
      KIND_SET: begin
        if ($urandom_range(0, 9) < 7) begin
          r.pos_x = near(sb.lo_x, sb.hi_x, 700);
          r.pos_y = near(sb.lo_y, sb.hi_y, 700);
        end
      end
      KIND_MOVE: begin
        r.pos_x = random_delta();
        r.pos_y = random_delta();
      end
      KIND_PLACE: begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          r.pos_x = near(sb.px, sb.px, 800);
          r.pos_y = near(sb.py, sb.py, 700);
        end else if (pick < 8) begin
          r.pos_x = near(sb.lo_x, sb.hi_x, 200);
          r.pos_y = near(sb.lo_y, sb.hi_y, 200);
        end
        if ($urandom_range(0, 4) != 0) begin
          r.elem_width = 16'($urandom_range(0, 300));
          r.elem_height = 16'($urandom_range(0, 300));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // offer one request after a gap and wait until it is taken
  task automatic push_request(input request_t req, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= req.kind;
    pos_x_i <= req.pos_x;
    pos_y_i <= req.pos_y;
    elem_width_i <= req.elem_width;
    elem_height_i <= req.elem_height;
    frame_time_i <= req.frame_time;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
  endtask

  // wait for all results, then let the pipeline empty
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // result sink with random stalls and one long hold-off
  initial begin : result_sink
    view_t got;
    int stall_len;
    int taken;
    bit quiet;
    taken = 0;
    quiet = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_results) begin
        stall_len = HOLD_CYCLES;
        hold_results = 1'b0;
      end else if (quiet) begin
        stall_len = 0;
      end else begin
        stall_len = $urandom_range(0, 18);
      end
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.scroll_x = scroll_x_o;
      got.scroll_y = scroll_y_o;
      got.draw_x = draw_x_o;
      got.draw_y = draw_y_o;
      got.on_screen = on_screen_o;
      got.wrap_right = wrap_right_o;
      got.wrap_bottom = wrap_bottom_o;
      sb.check_result(got);
      taken++;
      if (taken % 64 == 0) quiet = ($urandom_range(0, 2) == 0);
    end
  end

  // stimulus
  initial begin : request_source
    request_t directed[$];
    setting_e plan[9];
    int gap;
    sb = new();
    plan = '{SET_WINDOW, SET_FULL_FAST, SET_INVERTED, SET_WINDOW, SET_ANY,
             SET_ZERO, SET_WINDOW, SET_FULL_REVERSE, SET_WINDOW};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: toroidal window on both axes, auto scroll both ways
    apply_settings(32'(-200), 32'(900), 32'(-100), 32'(700), 32'hF,
                   32'(30720), 32'(-12800), 32'h0032_FFEC);
    directed.push_back(make_request(KIND_RESET, '0, '0, '0, '0, '0));
    directed.push_back(make_request(KIND_TICK, '0, '0, '0, '0, 16'd0));
    directed.push_back(make_request(KIND_TICK, '0, '0, '0, '0, 16'hFFFF));
    directed.push_back(make_request(KIND_TICK, '0, '0, '0, '0, 16'd1));
    // set far outside the bounds, then zero and unit moves
    directed.push_back(make_request(KIND_SET, 16'h7FFF, 16'h8000, '0, '0, '0));
    directed.push_back(make_request(KIND_MOVE, 16'd0, 16'd0, '0, '0, '0));
    directed.push_back(make_request(KIND_MOVE, 16'd1, 16'hFFFF, '0, '0, '0));
    directed.push_back(make_request(KIND_SET, 16'd0, 16'd0, '0, '0, '0));
    // largest deltas
    directed.push_back(make_request(KIND_MOVE, 16'h7FFF, 16'h8000, '0, '0, '0));
    directed.push_back(make_request(KIND_MOVE, 16'h8000, 16'h7FFF, '0, '0, '0));
    // pause holds the position through a tick
    directed.push_back(make_request(KIND_PAUSE, '0, '0, '0, '0, '0));
    directed.push_back(make_request(KIND_TICK, '0, '0, '0, '0, 16'd1000));
    directed.push_back(make_request(KIND_RESUME, '0, '0, '0, '0, '0));
    directed.push_back(make_request(KIND_TICK, '0, '0, '0, '0, 16'd1000));
    // near the right and bottom edges, wrap regions visible
    directed.push_back(make_request(KIND_SET, 16'd800, 16'd650, '0, '0, '0));
    directed.push_back(make_request(KIND_PLACE, 16'(-190), 16'(-90), 16'd50, 16'd40, '0));
    directed.push_back(make_request(KIND_PLACE, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, '0));
    directed.push_back(make_request(KIND_PLACE, 16'h7FFF, 16'h7FFF, 16'd0, 16'd0, '0));
    directed.push_back(make_request(KIND_PLACE, 16'd800, 16'd650, 16'd1, 16'd1, '0));
    directed.push_back(make_request(KIND_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF));
    directed.push_back(make_request(KIND_RESET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF));
    directed.push_back(make_request(KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'd37));
    foreach (directed[k]) push_request(directed[k], $urandom_range(0, 18));
    in_valid_i <= 1'b0;

    // random phases, each with its own register setting
    foreach (plan[phase]) begin
      settle();
      random_settings(plan[phase]);
      if (phase == 3) hold_results = 1'b1;
      push_request(make_request(KIND_RESET, 16'($urandom()), 16'($urandom()),
                                16'($urandom()), 16'($urandom()), 16'($urandom())), 0);
      for (int i = 1; i < PHASE_ITEMS; i++) begin
        if ((phase == 3 && i < 40) || (i >= PHASE_ITEMS / 3 && i < PHASE_ITEMS / 2)) gap = 0;
        else gap = $urandom_range(0, 18);
        push_request(random_request(), gap);
      end
      in_valid_i <= 1'b0;
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    $display("covered %0d ticks, %0d moves, %0d sets, %0d resets, %0d places over %0d settings",
             sb.kind_seen[KIND_TICK], sb.kind_seen[KIND_MOVE], sb.kind_seen[KIND_SET],
             sb.kind_seen[KIND_RESET], sb.kind_seen[KIND_PLACE], settings_count);
    $display("%0d results compared, %0d mismatches", sb.results, sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
